// ===== rtl/two_level_page_table_walker_macros.svh =====
// ----------------------------------------------------------------------------
// two_level_page_table_walker_macros
// Assertion macros shared by the walker modules. They compile to nothing in
// synthesis.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_PAGE_TABLE_WALKER_MACROS_SVH
`define TWO_LEVEL_PAGE_TABLE_WALKER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TLPTW_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define TLPTW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TLPTW_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define TLPTW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/tlptw_pkg.sv =====
// ----------------------------------------------------------------------------
// tlptw_pkg
// Types and codes shared by the page table walker front, queue and back.
// ----------------------------------------------------------------------------
package tlptw_pkg;

  typedef enum logic {
    OP_TRANSLATE = 1'b0,
    OP_RESPONSE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_L1   = 2'd1,
    PH_L2   = 2'd2
  } phase_t;

  // descriptor type field, bits 1:0
  localparam logic [1:0] DESC_FAULT   = 2'b00;
  localparam logic [1:0] DESC_COARSE  = 2'b01;  // large page at second level
  localparam logic [1:0] DESC_SECTION = 2'b10;  // small page at second level
  localparam logic [1:0] DESC_FINE    = 2'b11;  // fine table at first level, fault at second level

  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_DONE    = 1'b1;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_L1_FAULT = 2'd1;
  localparam logic [1:0] STAT_FINE     = 2'd2;
  localparam logic [1:0] STAT_L2_FAULT = 2'd3;

  localparam logic [1:0] MAP_SECTION = 2'd0;
  localparam logic [1:0] MAP_LARGE   = 2'd1;
  localparam logic [1:0] MAP_SMALL   = 2'd2;

  localparam int unsigned BASE_W = 18;

  typedef struct packed {
    op_t         op;
    logic [31:0] word;  // virtual address or descriptor
  } q_item_t;

  typedef struct packed {
    logic push;
    logic ready;
  } q_ctl_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] req_addr;
    logic [31:0] phys_addr;
    logic [1:0]  status;
    logic [1:0]  map_kind;
  } result_t;

endpackage

// ===== rtl/tlptw_front.sv =====
// ----------------------------------------------------------------------------
// tlptw_front
// Input stage: takes one beat per cycle while the queue has room, classifies
// the command, selects the operand word and hands the item to the queue.
// ----------------------------------------------------------------------------
module tlptw_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_command,
  input  logic [31:0]        in_virtual_address,
  input  logic [31:0]        in_read_data,
  output tlptw_pkg::q_ctl_t  q_ctl,
  input  logic               q_ready,
  output tlptw_pkg::q_item_t q_item
);

  logic               valid_r, valid_nxt;
  tlptw_pkg::q_item_t item_r, item_nxt;
  logic               accept;
  logic               push;

  assign push     = valid_r && q_ready;
  assign in_ready = !valid_r || q_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (push) begin
      valid_nxt = 1'b0;
    end
  end

  always_comb begin
    item_nxt = item_r;
    if (accept) begin
      if (in_command == 1'b0) begin
        item_nxt.op   = tlptw_pkg::OP_TRANSLATE;
        item_nxt.word = in_virtual_address;
      end else begin
        item_nxt.op   = tlptw_pkg::OP_RESPONSE;
        item_nxt.word = in_read_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign q_ctl.push  = push;
  assign q_ctl.ready = in_ready;
  assign q_item      = item_r;

endmodule

// ===== rtl/tlptw_queue.sv =====
// ----------------------------------------------------------------------------
// tlptw_queue
// Small in-order queue between the front and the back of the walker.
// ----------------------------------------------------------------------------
`include "two_level_page_table_walker_macros.svh"

module tlptw_queue #(
  parameter int unsigned DEPTH = 2  // power of two, at least 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tlptw_pkg::q_ctl_t  push_ctl,
  input  tlptw_pkg::q_item_t push_item,
  output logic               push_ready,
  output logic               pop_valid,
  input  logic               pop,
  output tlptw_pkg::q_item_t pop_item
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  tlptw_pkg::q_item_t mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_ctl.push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `TLPTW_ASSERT_IMPL(a_no_push_when_full, clk, rst_n, push_ctl.push, push_ready == push_ctl.ready || push_ready, "queue pushed while full")
  `TLPTW_ASSERT_IMPL(a_count_in_range, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH), "queue count overflow")
  `TLPTW_ASSERT_NEXT(a_count_tracks, clk, rst_n, do_push && !do_pop, count_r == $past(count_r) + 1'b1, "queue count did not grow on push")

endmodule

// ===== rtl/tlptw_back.sv =====
// ----------------------------------------------------------------------------
// tlptw_back
// Walk engine: holds the walk phase, the latched virtual address and the
// table base, decodes descriptors and drives the registered result beat.
// ----------------------------------------------------------------------------
`include "two_level_page_table_walker_macros.svh"

module tlptw_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [tlptw_pkg::BASE_W-1:0]   cfg_wr_data,
  input  logic                           q_valid,
  input  tlptw_pkg::q_item_t             q_item,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output tlptw_pkg::result_t             out_res
);

  tlptw_pkg::phase_t                phase_r, phase_nxt;
  logic [31:0]                      pending_r, pending_nxt;
  logic [tlptw_pkg::BASE_W-1:0]     base_r;
  logic                             out_valid_r, out_valid_nxt;
  tlptw_pkg::result_t               res_r, res_nxt;
  tlptw_pkg::result_t               res;
  logic                             emit;
  logic                             take;
  logic                             is_resp;
  logic [31:0]                      d;

  assign take    = q_valid && (!out_valid_r || out_ready);
  assign q_pop   = take;
  assign is_resp = (q_item.op == tlptw_pkg::OP_RESPONSE);
  assign d       = q_item.word;

  // next walk phase and latched address
  always_comb begin
    phase_nxt   = phase_r;
    pending_nxt = pending_r;
    case (phase_r)
      tlptw_pkg::PH_L1: begin
        if (is_resp) begin
          if (d[1:0] == tlptw_pkg::DESC_COARSE) begin
            phase_nxt = tlptw_pkg::PH_L2;
          end else begin
            phase_nxt = tlptw_pkg::PH_IDLE;
          end
        end
      end
      tlptw_pkg::PH_L2: begin
        if (is_resp) begin
          phase_nxt = tlptw_pkg::PH_IDLE;
        end
      end
      default: begin
        // idle, and the unused code behaves as idle
        if (!is_resp) begin
          phase_nxt   = tlptw_pkg::PH_L1;
          pending_nxt = d;
        end else begin
          phase_nxt = tlptw_pkg::PH_IDLE;
        end
      end
    endcase
  end

  // result beat for the current item
  always_comb begin
    emit         = 1'b0;
    res.kind      = tlptw_pkg::KIND_DONE;
    res.req_addr  = '0;
    res.phys_addr = '0;
    res.status    = tlptw_pkg::STAT_OK;
    res.map_kind  = tlptw_pkg::MAP_SECTION;
    case (phase_r)
      tlptw_pkg::PH_L1: begin
        if (is_resp) begin
          emit = 1'b1;
          case (d[1:0])
            tlptw_pkg::DESC_COARSE: begin
              res.kind     = tlptw_pkg::KIND_REQUEST;
              res.req_addr = {d[31:10], pending_r[19:12], 2'b00};
            end
            tlptw_pkg::DESC_SECTION: begin
              res.phys_addr = {d[31:20], pending_r[19:0]};
            end
            tlptw_pkg::DESC_FINE: begin
              res.status = tlptw_pkg::STAT_FINE;
            end
            default: begin
              res.status = tlptw_pkg::STAT_L1_FAULT;
            end
          endcase
        end
      end
      tlptw_pkg::PH_L2: begin
        if (is_resp) begin
          emit = 1'b1;
          case (d[1:0])
            tlptw_pkg::DESC_COARSE: begin
              res.phys_addr = {d[31:16], pending_r[15:0]};
              res.map_kind  = tlptw_pkg::MAP_LARGE;
            end
            tlptw_pkg::DESC_SECTION: begin
              res.phys_addr = {d[31:12], pending_r[11:0]};
              res.map_kind  = tlptw_pkg::MAP_SMALL;
            end
            default: begin
              res.status = tlptw_pkg::STAT_L2_FAULT;
            end
          endcase
        end
      end
      default: begin
        if (!is_resp) begin
          emit         = 1'b1;
          res.kind     = tlptw_pkg::KIND_REQUEST;
          res.req_addr = {base_r, d[31:20], 2'b00};
        end
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    if (take && emit) begin
      out_valid_nxt = 1'b1;
      res_nxt       = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= tlptw_pkg::PH_IDLE;
      pending_r   <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        phase_r   <= phase_nxt;
        pending_r <= pending_nxt;
      end
      if (cfg_wr_en) begin
        base_r <= cfg_wr_data;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  `TLPTW_ASSERT_IMPL(a_request_clean, clk, rst_n, out_valid_r && res_r.kind == tlptw_pkg::KIND_REQUEST, res_r.phys_addr == '0 && res_r.status == tlptw_pkg::STAT_OK && res_r.map_kind == tlptw_pkg::MAP_SECTION, "read request carries result fields")
  `TLPTW_ASSERT_IMPL(a_fault_clean, clk, rst_n, out_valid_r && res_r.status != tlptw_pkg::STAT_OK, res_r.kind == tlptw_pkg::KIND_DONE && res_r.phys_addr == '0 && res_r.req_addr == '0, "fault beat not clean")
  `TLPTW_ASSERT_NEXT(a_coarse_to_l2, clk, rst_n, take && is_resp && phase_r == tlptw_pkg::PH_L1 && d[1:0] == tlptw_pkg::DESC_COARSE, phase_r == tlptw_pkg::PH_L2 && out_valid_r, "coarse descriptor did not start second level")

endmodule

// ===== rtl/two_level_page_table_walker.sv =====
// ----------------------------------------------------------------------------
// two_level_page_table_walker
// Two-level translation table walker with coarse second-level tables.
// ----------------------------------------------------------------------------
// Each input beat is a translate command or a descriptor read back from
// memory; each may produce one result beat, either a descriptor read request
// or a finished translation with status. The block accepts one beat per clock
// while the queue has room and, with out_ready held high, returns results at
// one per clock; each beat passes the input register, a queue entry and the
// output register. Walk state is held and updated only in the back engine,
// in input order, and the queue of QUEUE_DEPTH entries lets input and output
// stall independently. A translate during a walk and a response while idle
// are dropped without a result. table_base may be rewritten only when idle.
module two_level_page_table_walker #(
  parameter int unsigned QUEUE_DEPTH = 2  // power of two, at least 2
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [tlptw_pkg::BASE_W-1:0] cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_command,
  input  logic [31:0]                  in_virtual_address,
  input  logic [31:0]                  in_read_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_result_kind,
  output logic [31:0]                  out_request_address,
  output logic [31:0]                  out_physical_address,
  output logic [1:0]                   out_status,
  output logic [1:0]                   out_mapping_kind
);

  tlptw_pkg::q_ctl_t  push_ctl;
  tlptw_pkg::q_item_t push_item;
  tlptw_pkg::q_item_t pop_item;
  tlptw_pkg::result_t res;
  logic               q_ready;
  logic               q_valid;
  logic               q_pop;

  tlptw_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_virtual_address (in_virtual_address),
    .in_read_data       (in_read_data),
    .q_ctl              (push_ctl),
    .q_ready            (q_ready),
    .q_item             (push_item)
  );

  tlptw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_ctl   (push_ctl),
    .push_item  (push_item),
    .push_ready (q_ready),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (pop_item)
  );

  tlptw_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_item      (pop_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_res     (res)
  );

  assign out_result_kind      = res.kind;
  assign out_request_address  = res.req_addr;
  assign out_physical_address = res.phys_addr;
  assign out_status           = res.status;
  assign out_mapping_kind     = res.map_kind;

endmodule

// ===== verif/page_walk_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_walk_checker
// Watches the walker's config port and both beat channels, keeps its own
// copy of the walk state and table base, and predicts each result beat at
// the time its input beat is accepted. Result beats are compared field by
// field against the oldest prediction; every mismatch is counted.
// ----------------------------------------------------------------------------
module page_walk_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [tlptw_pkg::BASE_W-1:0] cfg_wr_data,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic                         in_command,
  input  logic [31:0]                  in_virtual_address,
  input  logic [31:0]                  in_read_data,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic                         out_result_kind,
  input  logic [31:0]                  out_request_address,
  input  logic [31:0]                  out_physical_address,
  input  logic [1:0]                   out_status,
  input  logic [1:0]                   out_mapping_kind,
  output int unsigned                  mismatch_count,
  output int unsigned                  results_pending
);
  import tlptw_pkg::*;

  logic [BASE_W-1:0] table_base;
  phase_t            walk_phase;
  logic [31:0]       latched_va;
  result_t           pending_walk_results[$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%08h, expected 0x%08h",
             $time, what, got, want);
    mismatch_count++;
  endtask

  // advances the walk by one input beat; returns 1 when a result beat follows
  function automatic bit predict_walk_beat(input op_t op, input logic [31:0] va,
                                           input logic [31:0] desc,
                                           output result_t r);
    r = '0;
    if (op == OP_TRANSLATE) begin
      if (walk_phase == PH_L1 || walk_phase == PH_L2) return 1'b0;
      latched_va = va;
      walk_phase = PH_L1;
      r.kind     = KIND_REQUEST;
      r.req_addr = {table_base, va[31:20], 2'b00};
      return 1'b1;
    end
    case (walk_phase)
      PH_L1: begin
        walk_phase = PH_IDLE;
        r.kind     = KIND_DONE;
        case (desc[1:0])
          DESC_COARSE: begin
            walk_phase = PH_L2;
            r.kind     = KIND_REQUEST;
            r.req_addr = {desc[31:10], latched_va[19:12], 2'b00};
          end
          DESC_SECTION: begin
            r.phys_addr = {desc[31:20], latched_va[19:0]};
            r.map_kind  = MAP_SECTION;
          end
          DESC_FINE: r.status = STAT_FINE;
          default:   r.status = STAT_L1_FAULT;
        endcase
        return 1'b1;
      end
      PH_L2: begin
        walk_phase = PH_IDLE;
        r.kind     = KIND_DONE;
        case (desc[1:0])
          DESC_COARSE: begin
            r.phys_addr = {desc[31:16], latched_va[15:0]};
            r.map_kind  = MAP_LARGE;
          end
          DESC_SECTION: begin
            r.phys_addr = {desc[31:12], latched_va[11:0]};
            r.map_kind  = MAP_SMALL;
          end
          default: r.status = STAT_L2_FAULT;
        endcase
        return 1'b1;
      end
      default: begin
        // response with no walk in progress is dropped
        walk_phase = PH_IDLE;
        return 1'b0;
      end
    endcase
  endfunction

  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    if (!rst_n) begin
      table_base     = '0;
      walk_phase     = PH_IDLE;
      latched_va     = '0;
      mismatch_count = 0;
      pending_walk_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        got.kind      = out_result_kind;
        got.req_addr  = out_request_address;
        got.phys_addr = out_physical_address;
        got.status    = out_status;
        got.map_kind  = out_mapping_kind;
        if (pending_walk_results.size() == 0) begin
          report_mismatch("result beat with none pending, request_address",
                          got.req_addr, 32'h0);
        end else begin
          want = pending_walk_results.pop_front();
          if (got.kind !== want.kind)
            report_mismatch("result_kind", got.kind, want.kind);
          if (got.req_addr !== want.req_addr)
            report_mismatch("request_address", got.req_addr, want.req_addr);
          if (got.phys_addr !== want.phys_addr)
            report_mismatch("physical_address", got.phys_addr, want.phys_addr);
          if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
          if (got.map_kind !== want.map_kind)
            report_mismatch("mapping_kind", got.map_kind, want.map_kind);
        end
      end
      if (in_valid && in_ready) begin
        if (predict_walk_beat(op_t'(in_command), in_virtual_address, in_read_data,
                              want))
          pending_walk_results.push_back(want);
      end
      // a new base only applies to walks started after this edge
      if (cfg_wr_en) table_base = cfg_wr_data;
    end
    results_pending <= pending_walk_results.size();
  end

endmodule

// ===== verif/two_level_page_table_walker_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_page_table_walker_tb
// Drives translate commands and descriptor beats into the page table walker,
// first a directed set covering every descriptor type at both levels, then
// random walks under several table bases with stray beats mixed in. Both
// channels stall at random; one phase holds the output off for a long time.
// ----------------------------------------------------------------------------
module two_level_page_table_walker_tb;
  import tlptw_pkg::*;

  localparam int unsigned CLK_PERIOD      = 12;
  localparam int unsigned WALKS_PER_PHASE = 172;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned SETTLE_CYCLES   = 12;
  localparam int unsigned DRAIN_LIMIT     = 20000;
  localparam int unsigned LIMIT_CYCLES    = 200000;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [BASE_W-1:0] cfg_wr_data;
  logic              in_valid;
  logic              in_ready;
  logic              in_command;
  logic [31:0]       in_virtual_address;
  logic [31:0]       in_read_data;
  logic              out_valid;
  logic              out_ready;
  logic              out_result_kind;
  logic [31:0]       out_request_address;
  logic [31:0]       out_physical_address;
  logic [1:0]        out_status;
  logic [1:0]        out_mapping_kind;

  int unsigned mismatch_count;
  int unsigned results_pending;

  // stimulus controls read by the input and output sides
  logic calm;
  logic hold_req;

  int unsigned n_translate;
  int unsigned n_response;
  int unsigned n_ignored;
  int unsigned n_bases;

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  two_level_page_table_walker uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_virtual_address  (in_virtual_address),
    .in_read_data        (in_read_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_result_kind     (out_result_kind),
    .out_request_address (out_request_address),
    .out_physical_address(out_physical_address),
    .out_status          (out_status),
    .out_mapping_kind    (out_mapping_kind)
  );

  page_walk_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_virtual_address  (in_virtual_address),
    .in_read_data        (in_read_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_result_kind     (out_result_kind),
    .out_request_address (out_request_address),
    .out_physical_address(out_physical_address),
    .out_status          (out_status),
    .out_mapping_kind    (out_mapping_kind),
    .mismatch_count      (mismatch_count),
    .results_pending     (results_pending)
  );

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_beat(input op_t op, input logic [31:0] va,
                           input logic [31:0] data);
    while (!calm && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_command         <= op;
    in_virtual_address <= va;
    in_read_data       <= data;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic translate(input logic [31:0] va);
    send_beat(OP_TRANSLATE, va, $urandom());
    n_translate++;
  endtask

  task automatic respond(input logic [31:0] desc);
    send_beat(OP_RESPONSE, $urandom(), desc);
    n_response++;
  endtask

  // beat the walker should drop: translate mid-walk or response while idle
  task automatic stray(input op_t op);
    send_beat(op, $urandom(), $urandom());
    n_ignored++;
  endtask

  task automatic walk(input logic [31:0] va, input logic [31:0] l1,
                      input logic [31:0] l2);
    translate(va);
    respond(l1);
    if (l1[1:0] == DESC_COARSE) respond(l2);
  endtask

  function automatic logic [31:0] rand_desc(input logic [1:0] code);
    logic [31:0] w;
    w = $urandom();
    return {w[31:2], code};
  endfunction

  task automatic random_walks(input int unsigned n);
    int unsigned done;
    int unsigned pick;
    logic [1:0]  l1_code;
    logic [1:0]  l2_code;
    done = 0;
    while (done < n) begin
      pick    = $urandom_range(99);
      l1_code = pick < 45 ? DESC_COARSE : pick < 75 ? DESC_SECTION :
                pick < 88 ? DESC_FAULT : DESC_FINE;
      pick    = $urandom_range(99);
      l2_code = pick < 35 ? DESC_COARSE : pick < 70 ? DESC_SECTION :
                pick < 85 ? DESC_FAULT : DESC_FINE;
      translate($urandom());
      if ($urandom_range(99) < 8) stray(OP_TRANSLATE);
      respond(rand_desc(l1_code));
      done += 2;
      if (l1_code == DESC_COARSE) begin
        if ($urandom_range(99) < 8) stray(OP_TRANSLATE);
        respond(rand_desc(l2_code));
        done++;
      end
      if ($urandom_range(99) < 8) stray(OP_RESPONSE);
    end
  endtask

  // base changes only once every walk has drained out of the pipeline
  task automatic program_base(input logic [BASE_W-1:0] base);
    in_valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= base;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    n_bases++;
  endtask

  initial begin : receiver
    bit held;
    held = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= calm || ($urandom_range(99) >= 6);
    end
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("timeout after %0d cycles", LIMIT_CYCLES);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned waited;
    n_translate = 0;
    n_response  = 0;
    n_ignored   = 0;
    n_bases     = 0;
    rst_n              <= 1'b0;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= '0;
    in_valid           <= 1'b0;
    in_command         <= OP_TRANSLATE;
    in_virtual_address <= '0;
    in_read_data       <= '0;
    calm               <= 1'b0;
    hold_req           <= 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    program_base({BASE_W{1'b1}});
    // sections with all-ones and all-zero words
    walk(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h0);
    walk(32'h0000_0000, 32'h0000_0002, 32'h0);
    // coarse table into large and small pages
    walk(32'hFFFF_FFFF, 32'hFFFF_FFFD, 32'hFFFF_FFFD);
    walk(32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFE);
    // second-level fault from a fault and a fine descriptor
    walk(32'h1234_5678, rand_desc(DESC_COARSE), 32'h0000_0000);
    walk($urandom(), rand_desc(DESC_COARSE), 32'hFFFF_FFFF);
    // first-level fault and fine table
    walk($urandom(), 32'h0000_0000, 32'h0);
    walk($urandom(), 32'hFFFF_FFFF, 32'h0);
    // response while idle, then a translate during a walk
    stray(OP_RESPONSE);
    translate($urandom());
    stray(OP_TRANSLATE);
    respond(rand_desc(DESC_SECTION));

    program_base('0);
    random_walks(WALKS_PER_PHASE);

    program_base(BASE_W'($urandom_range(2 ** BASE_W - 1)));
    hold_req <= 1'b1;
    random_walks(WALKS_PER_PHASE);

    program_base({BASE_W{1'b1}});
    calm <= 1'b1;
    random_walks(WALKS_PER_PHASE);

    program_base(BASE_W'($urandom_range(2 ** BASE_W - 1)));
    calm <= 1'b0;
    random_walks(WALKS_PER_PHASE);

    program_base(BASE_W'($urandom_range(2 ** BASE_W - 1)));
    random_walks(WALKS_PER_PHASE);

    in_valid <= 1'b0;
    waited = 0;
    while (results_pending != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d translations and %0d descriptor beats, %0d dropped beats",
             n_translate, n_response, n_ignored);
    $display("over %0d table bases, with a %0d-cycle output hold and a stall-free phase",
             n_bases, HOLD_CYCLES);
    if (results_pending == 0 && mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tlptw_pkg.sv
rtl/tlptw_front.sv
rtl/tlptw_queue.sv
rtl/tlptw_back.sv
rtl/two_level_page_table_walker.sv
verif/page_walk_checker.sv
verif/two_level_page_table_walker_tb.sv
